>>> sv/pfilt_pkg.sv
// shared types and constants of the ethertype / ip protocol packet filter
package pfilt_pkg;

	localparam int OUT_CNT_W  = 48;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [15:0] TYPE_IPV4 = 16'h0800;
	localparam logic [15:0] TYPE_VLAN = 16'h8100;

	localparam logic [15:0] OFS_TYPE_HI  = 16'd12;
	localparam logic [15:0] OFS_TYPE_LO  = 16'd13;
	localparam logic [15:0] OFS_INNER_HI = 16'd16;
	localparam logic [15:0] OFS_INNER_LO = 16'd17;
	localparam logic [15:0] OFS_PROTO    = 16'd23;
	localparam logic [15:0] OFS_PROTO_VL = 16'd27;
	localparam logic [15:0] MIN_TYPE_LEN = 16'd14;
	localparam logic [15:0] OFS_MAX      = 16'hFFFF;

	localparam logic REQ_BYTE  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	localparam logic KIND_ETYPE = 1'b0;
	localparam logic KIND_PROTO = 1'b1;

	localparam logic ACT_PASS = 1'b0;
	localparam logic ACT_DROP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_ACTION   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ACTION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT    = 2'd2;

	typedef struct packed {
		logic        kind;
		logic [15:0] value;
	} tbl_entry_t;

	typedef struct packed {
		logic       en;
		logic [4:0] index;
		tbl_entry_t entry;
	} tbl_wr_t;

	typedef struct packed {
		logic        outer_ok;
		logic [15:0] outer_type;
		logic        proto_seen;
		logic [7:0]  proto_number;
	} match_key_t;

	typedef struct packed {
		logic done;
		logic hit;
	} scan_res_t;

endpackage

>>> sv/ethertype_ipproto_packet_filter_core.sv
// ethertype / ip protocol packet filter top level
//
//  channel | handshake             | beat
//  --------+-----------------------+------------------------------------------------
//  in      | in_valid / in_ready   | req_type pkt_byte last_byte entry_* (byte or entry)
//  out     | out_valid / out_ready | verdict matched frame_length counters
//  cfg     | cfg_valid / cfg_ready | cfg_index cfg_data
//
// each frame byte and each table write is one beat on the in channel
// a last byte starts a scan of min(entry_count, TABLE_ENTRIES) entries, one memory read each;
// in_ready stays low through S_SCAN and S_EMIT and returns when the result register takes the verdict
// the result register frees the input side; a stalled output only holds a later frame end
// reset clears counters, parse state and registers; the table holds no reset value
// cfg_ready is always high
module ethertype_ipproto_packet_filter_core
	import pfilt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 32,
	parameter int COUNTER_BITS  = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic [7:0]            pkt_byte,
	input  logic                  last_byte,
	input  logic [4:0]            entry_index,
	input  logic                  entry_kind,
	input  logic [15:0]           entry_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  verdict,
	output logic                  matched,
	output logic [15:0]           frame_length,
	output logic [OUT_CNT_W-1:0]  passed_frames,
	output logic [OUT_CNT_W-1:0]  dropped_frames,
	output logic [OUT_CNT_W-1:0]  passed_bytes
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EMIT
	} state_t;

	state_t                  state_q;
	logic                    match_action_q;
	logic                    default_action_q;
	logic [5:0]              entry_count_q;
	logic [15:0]             offset_q;
	logic [15:0]             outer_type_q;
	logic [15:0]             inner_type_q;
	logic [7:0]              proto_q;
	logic                    proto_seen_q;
	logic                    hit_q;
	logic [COUNTER_BITS-1:0] pass_cnt_q;
	logic [COUNTER_BITS-1:0] drop_cnt_q;
	logic [COUNTER_BITS-1:0] byte_cnt_q;
	logic                    out_valid_q;
	logic                    verdict_q;
	logic                    matched_q;
	logic [15:0]             len_q;
	logic [COUNTER_BITS-1:0] pass_out_q;
	logic [COUNTER_BITS-1:0] drop_out_q;
	logic [COUNTER_BITS-1:0] bytes_out_q;

	logic       in_acc;
	logic       byte_acc;
	logic       out_free;
	logic       verdict_nx;
	tbl_wr_t    tbl_wr;
	match_key_t key;
	scan_res_t  scan_res;

	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == S_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign byte_acc   = in_acc && (req_type == REQ_BYTE);
	assign out_free   = !out_valid_q || out_ready;
	assign verdict_nx = hit_q ? match_action_q : default_action_q;

	assign tbl_wr.en          = in_acc && (req_type == REQ_WRITE);
	assign tbl_wr.index       = entry_index;
	assign tbl_wr.entry.kind  = entry_kind;
	assign tbl_wr.entry.value = entry_value;

	assign key.outer_ok     = (offset_q >= MIN_TYPE_LEN);
	assign key.outer_type   = outer_type_q;
	assign key.proto_seen   = proto_seen_q;
	assign key.proto_number = proto_q;

	pfilt_scan #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (tbl_wr),
		.start      (byte_acc && last_byte),
		.entry_count(entry_count_q),
		.key        (key),
		.res        (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_action_q   <= ACT_PASS;
			default_action_q <= ACT_PASS;
			entry_count_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MATCH_ACTION:   match_action_q   <= cfg_data[0];
				CFG_DEFAULT_ACTION: default_action_q <= cfg_data[0];
				CFG_ENTRY_COUNT:    entry_count_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			offset_q     <= '0;
			outer_type_q <= '0;
			inner_type_q <= '0;
			proto_q      <= '0;
			proto_seen_q <= 1'b0;
			hit_q        <= 1'b0;
			pass_cnt_q   <= '0;
			drop_cnt_q   <= '0;
			byte_cnt_q   <= '0;
			out_valid_q  <= 1'b0;
			verdict_q    <= ACT_PASS;
			matched_q    <= 1'b0;
			len_q        <= '0;
			pass_out_q   <= '0;
			drop_out_q   <= '0;
			bytes_out_q  <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (byte_acc) begin
						if (offset_q == OFS_TYPE_HI) outer_type_q[15:8] <= pkt_byte;
						if (offset_q == OFS_TYPE_LO) outer_type_q[7:0]  <= pkt_byte;
						if (offset_q == OFS_INNER_HI) inner_type_q[15:8] <= pkt_byte;
						if (offset_q == OFS_INNER_LO) inner_type_q[7:0]  <= pkt_byte;
						if ((offset_q == OFS_PROTO && outer_type_q == TYPE_IPV4) ||
							(offset_q == OFS_PROTO_VL && outer_type_q == TYPE_VLAN &&
							inner_type_q == TYPE_IPV4)) begin
							proto_q      <= pkt_byte;
							proto_seen_q <= 1'b1;
						end
						if (offset_q != OFS_MAX) begin
							offset_q <= offset_q + 16'd1;
						end
						if (last_byte) begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_res.done) begin
						hit_q   <= scan_res.hit;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						verdict_q   <= verdict_nx;
						matched_q   <= hit_q;
						len_q       <= offset_q;
						if (verdict_nx == ACT_PASS) begin
							pass_cnt_q  <= pass_cnt_q + 1'b1;
							byte_cnt_q  <= byte_cnt_q + COUNTER_BITS'(offset_q);
							pass_out_q  <= pass_cnt_q + 1'b1;
							bytes_out_q <= byte_cnt_q + COUNTER_BITS'(offset_q);
							drop_out_q  <= drop_cnt_q;
						end else begin
							drop_cnt_q  <= drop_cnt_q + 1'b1;
							drop_out_q  <= drop_cnt_q + 1'b1;
							pass_out_q  <= pass_cnt_q;
							bytes_out_q <= byte_cnt_q;
						end
						offset_q     <= '0;
						outer_type_q <= '0;
						inner_type_q <= '0;
						proto_q      <= '0;
						proto_seen_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign verdict        = verdict_q;
	assign matched        = matched_q;
	assign frame_length   = len_q;
	assign passed_frames  = OUT_CNT_W'(pass_out_q);
	assign dropped_frames = OUT_CNT_W'(drop_out_q);
	assign passed_bytes   = OUT_CNT_W'(bytes_out_q);

endmodule

>>> sv/pfilt_scan.sv
// match table memory and the sequential entry scan
module pfilt_scan
	import pfilt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  tbl_wr_t    wr,
	input  logic       start,
	input  logic [5:0] entry_count,
	input  match_key_t key,
	output scan_res_t  res
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	tbl_entry_t       tbl_mem_q [TABLE_ENTRIES];
	tbl_entry_t       rd_data_s1;
	logic             rd_vld_s1;
	logic             busy_q;
	logic             hit_q;
	logic [CNT_W-1:0] addr_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] n_lim;
	logic             issue;
	logic             wr_ok;
	logic             entry_hit;

	assign n_lim = (32'(entry_count) > TABLE_ENTRIES) ? CNT_W'(TABLE_ENTRIES)
		: CNT_W'(entry_count);
	assign issue = busy_q && (addr_q < n_q);
	assign wr_ok = wr.en && (32'(wr.index) < TABLE_ENTRIES);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			tbl_mem_q[IDX_W'(wr.index)] <= wr.entry;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= tbl_mem_q[addr_q[IDX_W-1:0]];
		end
	end

	always_comb begin
		if (rd_data_s1.kind == KIND_ETYPE) begin
			entry_hit = key.outer_ok && (rd_data_s1.value == key.outer_type);
		end else begin
			entry_hit = key.proto_seen && (rd_data_s1.value[7:0] == key.proto_number);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			hit_q     <= 1'b0;
			addr_q    <= '0;
			n_q       <= '0;
			rd_vld_s1 <= 1'b0;
		end else if (start && !busy_q) begin
			busy_q    <= 1'b1;
			hit_q     <= 1'b0;
			addr_q    <= '0;
			n_q       <= n_lim;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				addr_q <= addr_q + 1'b1;
			end
			if (rd_vld_s1 && entry_hit) begin
				hit_q <= 1'b1;
			end
			if (res.done) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign res.done = busy_q && !issue && !rd_vld_s1;
	assign res.hit  = hit_q;

endmodule

>>> sv/pfilt_checker.sv
// port-level checks for the packet filter top level, with its bind
module pfilt_checker
	import pfilt_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  req_type,
	input logic                  last_byte,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  verdict,
	input logic                  matched,
	input logic [15:0]           frame_length,
	input logic [OUT_CNT_W-1:0]  passed_frames,
	input logic [OUT_CNT_W-1:0]  dropped_frames,
	input logic [OUT_CNT_W-1:0]  passed_bytes
);

	logic match_act_q;
	logic default_act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_act_q   <= ACT_PASS;
			default_act_q <= ACT_PASS;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_MATCH_ACTION) match_act_q <= cfg_data[0];
			if (cfg_index == CFG_DEFAULT_ACTION) default_act_q <= cfg_data[0];
		end
	end

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(matched) &&
		$stable(frame_length) && $stable(passed_frames) && $stable(dropped_frames) &&
		$stable(passed_bytes))
		else $error("result beat changed while stalled");

	// verdict follows the configured action for hit or miss
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> verdict == (matched ? match_act_q : default_act_q))
		else $error("verdict does not follow configured action");

	// every frame carries at least one byte
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_length != 16'd0)
		else $error("empty frame reported");

	// a frame end blocks the input side while the table is scanned
	a_scan_block: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && req_type == REQ_BYTE && last_byte |=> !in_ready)
		else $error("input accepted during table scan");

endmodule

bind ethertype_ipproto_packet_filter_core pfilt_checker u_pfilt_checker (.*);

>>> tb/tb_ethertype_ipproto_packet_filter_core.sv
`timescale 1ns / 100ps
// testbench of the ethertype / ip protocol packet filter core with a self-checking verdict predictor
module tb_ethertype_ipproto_packet_filter_core;
	import pfilt_pkg::*;

	localparam int TABLE_ENTRIES  = 32;
	localparam int COUNTER_BITS   = 48;
	localparam int SETTLE_CYCLES  = 64;
	localparam int CYCLE_LIMIT    = 1500000;
	localparam int LONG_FRAME_LEN = 65540;
	localparam int RANDOM_ITEMS   = 1600;
	localparam int RANDOM_FRAMES  = 60;
	localparam int RANDOM_PHASES  = 8;
	localparam int PRINT_LIMIT    = 40;
	localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd3;

	typedef logic [7:0] frame_bytes_t[$];

	typedef struct packed {
		logic                 verdict;
		logic                 matched;
		logic [15:0]          frame_length;
		logic [OUT_CNT_W-1:0] passed_frames;
		logic [OUT_CNT_W-1:0] dropped_frames;
		logic [OUT_CNT_W-1:0] passed_bytes;
	} verdict_beat_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  req_type;
	logic [7:0]            pkt_byte;
	logic                  last_byte;
	logic [4:0]            entry_index;
	logic                  entry_kind;
	logic [15:0]           entry_value;
	logic                  out_valid;
	logic                  out_ready;
	logic                  verdict;
	logic                  matched;
	logic [15:0]           frame_length;
	logic [OUT_CNT_W-1:0]  passed_frames;
	logic [OUT_CNT_W-1:0]  dropped_frames;
	logic [OUT_CNT_W-1:0]  passed_bytes;

	// predictor state
	tbl_entry_t              filter_table[TABLE_ENTRIES];
	logic [15:0]             parse_offset;
	logic [15:0]             parse_outer;
	logic [15:0]             parse_inner;
	logic [7:0]              parse_proto;
	logic                    parse_proto_seen;
	logic [COUNTER_BITS-1:0] pass_total;
	logic [COUNTER_BITS-1:0] drop_total;
	logic [COUNTER_BITS-1:0] pass_byte_total;
	logic                    cfg_match_act;
	logic                    cfg_default_act;
	logic [5:0]              cfg_entry_count;

	verdict_beat_t pending_verdicts[$];
	int            fail_count;
	int            items_sent;
	int            frames_sent;
	int            cycle_count;
	bit            steady_phase;

	ethertype_ipproto_packet_filter_core #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.COUNTER_BITS (COUNTER_BITS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.pkt_byte      (pkt_byte),
		.last_byte     (last_byte),
		.entry_index   (entry_index),
		.entry_kind    (entry_kind),
		.entry_value   (entry_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.verdict       (verdict),
		.matched       (matched),
		.frame_length  (frame_length),
		.passed_frames (passed_frames),
		.dropped_frames(dropped_frames),
		.passed_bytes  (passed_bytes)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ethertype_ipproto_packet_filter_core regression: fail");
		$finish;
	end

	always @(negedge clk) begin
		out_ready <= steady_phase || ($urandom_range(0, 99) >= 7);
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (fail_count < PRINT_LIMIT)
			$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic check_field(input string what, input logic [63:0] got, input logic [63:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin : verdict_check
		verdict_beat_t want;
		if (out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch("verdict beat with none expected", {63'd0, verdict}, 64'd0);
			end else begin
				want = pending_verdicts.pop_front();
				check_field("verdict", 64'(verdict), 64'(want.verdict));
				check_field("matched", 64'(matched), 64'(want.matched));
				check_field("frame_length", 64'(frame_length), 64'(want.frame_length));
				check_field("passed_frames", 64'(passed_frames), 64'(want.passed_frames));
				check_field("dropped_frames", 64'(dropped_frames), 64'(want.dropped_frames));
				check_field("passed_bytes", 64'(passed_bytes), 64'(want.passed_bytes));
			end
		end
	end

	// updates the predictor with one accepted input beat and queues the expected verdict if it ends a frame
	task automatic predict_verdict(input logic rt, input logic [7:0] b, input logic lst,
		input logic [4:0] idx, input logic knd, input logic [15:0] val);
		int            scan_len;
		logic          hit;
		logic          act;
		logic [15:0]   len;
		verdict_beat_t exp_beat;
		if (rt == REQ_WRITE) begin
			if (idx < TABLE_ENTRIES) begin
				filter_table[idx].kind  = knd;
				filter_table[idx].value = val;
			end
		end else begin
			case (parse_offset)
				OFS_TYPE_HI:  parse_outer[15:8] = b;
				OFS_TYPE_LO:  parse_outer[7:0] = b;
				OFS_INNER_HI: parse_inner[15:8] = b;
				OFS_INNER_LO: parse_inner[7:0] = b;
				OFS_PROTO: begin
					if (parse_outer == TYPE_IPV4) begin
						parse_proto      = b;
						parse_proto_seen = 1'b1;
					end
				end
				OFS_PROTO_VL: begin
					if (parse_outer == TYPE_VLAN && parse_inner == TYPE_IPV4) begin
						parse_proto      = b;
						parse_proto_seen = 1'b1;
					end
				end
				default: ;
			endcase
			if (parse_offset != OFS_MAX)
				parse_offset++;
			if (lst) begin
				len      = parse_offset;
				scan_len = (cfg_entry_count > TABLE_ENTRIES) ? TABLE_ENTRIES : cfg_entry_count;
				hit      = 1'b0;
				for (int j = 0; j < scan_len; j++) begin
					if (filter_table[j].kind == KIND_ETYPE) begin
						if (len >= MIN_TYPE_LEN && filter_table[j].value == parse_outer)
							hit = 1'b1;
					end else begin
						if (parse_proto_seen && filter_table[j].value[7:0] == parse_proto)
							hit = 1'b1;
					end
				end
				act = hit ? cfg_match_act : cfg_default_act;
				if (act == ACT_PASS) begin
					pass_total++;
					pass_byte_total += COUNTER_BITS'(len);
				end else begin
					drop_total++;
				end
				exp_beat.verdict        = act;
				exp_beat.matched        = hit;
				exp_beat.frame_length   = len;
				exp_beat.passed_frames  = pass_total[OUT_CNT_W-1:0];
				exp_beat.dropped_frames = drop_total[OUT_CNT_W-1:0];
				exp_beat.passed_bytes   = pass_byte_total[OUT_CNT_W-1:0];
				pending_verdicts.push_back(exp_beat);
				parse_offset     = '0;
				parse_outer      = '0;
				parse_inner      = '0;
				parse_proto      = '0;
				parse_proto_seen = 1'b0;
			end
		end
	endtask

	// called and returns at a falling edge; leaves in_valid high
	task automatic send_beat(input logic rt, input logic [7:0] b, input logic lst,
		input logic [4:0] idx, input logic knd, input logic [15:0] val);
		while (!steady_phase && $urandom_range(0, 99) < 7) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= rt;
		pkt_byte    <= b;
		last_byte   <= lst;
		entry_index <= idx;
		entry_kind  <= knd;
		entry_value <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_verdict(rt, b, lst, idx, knd, val);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_table_write(input logic [4:0] idx, input logic knd, input logic [15:0] val);
		send_beat(REQ_WRITE, 8'($urandom), 1'($urandom), idx, knd, val);
	endtask

	task automatic send_frame(input frame_bytes_t bytes, input int write_pct);
		for (int i = 0; i < bytes.size(); i++) begin
			if ($urandom_range(0, 99) < write_pct)
				send_table_write(5'($urandom), 1'($urandom), 16'($urandom));
			send_beat(REQ_BYTE, bytes[i], i == bytes.size() - 1, 5'($urandom), 1'($urandom),
				16'($urandom));
		end
		frames_sent++;
	endtask

	function automatic frame_bytes_t build_frame(input int len, input logic [15:0] outer,
		input logic [15:0] inner, input logic [7:0] proto);
		frame_bytes_t bytes;
		for (int i = 0; i < len; i++)
			bytes.push_back(8'($urandom));
		if (len > OFS_TYPE_HI)
			bytes[OFS_TYPE_HI] = outer[15:8];
		if (len > OFS_TYPE_LO)
			bytes[OFS_TYPE_LO] = outer[7:0];
		if (outer == TYPE_VLAN) begin
			if (len > OFS_INNER_HI)
				bytes[OFS_INNER_HI] = inner[15:8];
			if (len > OFS_INNER_LO)
				bytes[OFS_INNER_LO] = inner[7:0];
			if (len > OFS_PROTO_VL)
				bytes[OFS_PROTO_VL] = proto;
		end else if (len > OFS_PROTO) begin
			bytes[OFS_PROTO] = proto;
		end
		return bytes;
	endfunction

	// wait for every verdict, then let the core idle with in_valid low
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_MATCH_ACTION:   cfg_match_act = data[0];
			CFG_DEFAULT_ACTION: cfg_default_act = data[0];
			CFG_ENTRY_COUNT:    cfg_entry_count = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic apply_settings(input logic match_act, input logic default_act,
		input logic [5:0] count);
		settle();
		write_register(CFG_MATCH_ACTION, {5'($urandom_range(0, 31)), match_act});
		write_register(CFG_RESERVED, 6'($urandom));
		write_register(CFG_DEFAULT_ACTION, {5'($urandom_range(0, 31)), default_act});
		write_register(CFG_ENTRY_COUNT, count);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_frame();
		int          len;
		logic [15:0] outer;
		logic [15:0] inner;
		logic [7:0]  proto;
		tbl_entry_t  pick;
		pick  = filter_table[$urandom_range(0, TABLE_ENTRIES - 1)];
		proto = $urandom_range(0, 1) ? pick.value[7:0] : 8'($urandom);
		inner = TYPE_IPV4;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				outer = TYPE_IPV4;
				len   = $urandom_range(24, 48);
			end
			4, 5: begin
				outer = TYPE_VLAN;
				len   = $urandom_range(28, 48);
			end
			6: begin
				outer = pick.value;
				len   = $urandom_range(14, 40);
			end
			7: begin
				outer = $urandom_range(0, 1) ? TYPE_IPV4 : TYPE_VLAN;
				len   = $urandom_range(1, 27);
			end
			8: begin
				outer = 16'($urandom);
				inner = 16'($urandom);
				len   = $urandom_range(1, 48);
			end
			default: begin
				outer = TYPE_VLAN;
				inner = 16'($urandom);
				len   = $urandom_range(14, 48);
			end
		endcase
		if ($urandom_range(0, 9) == 0)
			send_table_write(5'($urandom), 1'($urandom), 16'($urandom));
		send_frame(build_frame(len, outer, inner, proto), 3);
	endtask

	task automatic test_table_fill();
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			case (i)
				0:                 send_table_write(5'(i), KIND_ETYPE, 16'h86DD);
				1:                 send_table_write(5'(i), KIND_PROTO, 16'hAB11);
				2:                 send_table_write(5'(i), KIND_ETYPE, 16'h0000);
				3:                 send_table_write(5'(i), KIND_PROTO, 16'h0000);
				TABLE_ENTRIES - 1: send_table_write(5'(i), KIND_ETYPE, 16'hFFFF);
				default:           send_table_write(5'(i), 1'($urandom), 16'($urandom));
			endcase
		end
	endtask

	task automatic test_header_parse();
		apply_settings(ACT_DROP, ACT_PASS, 6'd32);
		send_frame(build_frame(1, 16'h0000, 16'h0000, 8'h00), 0);
		send_frame(build_frame(13, 16'h86DD, 16'h0000, 8'h00), 0);
		send_frame(build_frame(14, 16'h86DD, 16'h0000, 8'h00), 0);
		send_frame(build_frame(14, 16'h0000, 16'h0000, 8'h00), 0);
		send_frame(build_frame(23, TYPE_IPV4, 16'h0000, 8'h11), 0);
		send_frame(build_frame(24, TYPE_IPV4, 16'h0000, 8'h11), 0);
		send_frame(build_frame(24, TYPE_IPV4, 16'h0000, 8'h00), 0);
		send_frame(build_frame(60, TYPE_IPV4, 16'h0000, 8'h06), 0);
		send_frame(build_frame(27, TYPE_VLAN, TYPE_IPV4, 8'h11), 0);
		send_frame(build_frame(28, TYPE_VLAN, TYPE_IPV4, 8'h11), 0);
		send_frame(build_frame(28, TYPE_VLAN, 16'h86DD, 8'h11), 0);
		send_frame(build_frame(40, TYPE_IPV4, 16'h0000, 8'hFF), 0);
		send_frame(build_frame(64, 16'hFFFF, 16'hFFFF, 8'hFF), 0);
	endtask

	task automatic test_entry_count();
		apply_settings(ACT_DROP, ACT_PASS, 6'd0);
		send_frame(build_frame(14, 16'h86DD, 16'h0000, 8'h00), 0);
		apply_settings(ACT_DROP, ACT_PASS, 6'd1);
		send_frame(build_frame(14, 16'h86DD, 16'h0000, 8'h00), 0);
		send_frame(build_frame(24, TYPE_IPV4, 16'h0000, 8'h11), 0);
		apply_settings(ACT_DROP, ACT_PASS, 6'd33);
		send_frame(build_frame(64, 16'hFFFF, 16'hFFFF, 8'hFF), 0);
		apply_settings(ACT_DROP, ACT_PASS, 6'd63);
		send_frame(build_frame(28, TYPE_VLAN, TYPE_IPV4, 8'h11), 0);
	endtask

	task automatic test_actions();
		for (int a = 0; a < 4; a++) begin
			apply_settings(a[0] ? ACT_DROP : ACT_PASS, a[1] ? ACT_DROP : ACT_PASS, 6'd32);
			send_frame(build_frame(14, 16'h86DD, 16'h0000, 8'h00), 0);
			send_frame(build_frame(30, TYPE_IPV4, 16'h0000, 8'h06), 0);
		end
	endtask

	task automatic test_table_write_midframe();
		apply_settings(ACT_DROP, ACT_PASS, 6'd32);
		send_frame(build_frame(40, TYPE_IPV4, 16'h0000, 8'h11), 50);
		send_frame(build_frame(30, TYPE_VLAN, TYPE_IPV4, 8'h11), 50);
	endtask

	task automatic test_long_frame();
		apply_settings(ACT_PASS, ACT_DROP, 6'd32);
		send_frame(build_frame(LONG_FRAME_LEN, TYPE_IPV4, 16'h0000, 8'h11), 0);
		send_frame(build_frame(20, TYPE_IPV4, 16'h0000, 8'h11), 0);
	endtask

	task automatic test_random_traffic();
		int       phase_start;
		int       frame_start;
		logic [5:0] count;
		frame_start = frames_sent;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0:       count = 6'd32;
				1:       count = 6'd8;
				2:       count = 6'd1;
				3:       count = 6'd63;
				4:       count = 6'd0;
				5:       count = 6'd33;
				6:       count = 6'($urandom);
				default: count = 6'd32;
			endcase
			apply_settings(p[0] ? ACT_DROP : ACT_PASS, p[1] ? ACT_DROP : ACT_PASS, count);
			steady_phase = (p == RANDOM_PHASES - 2);
			phase_start  = items_sent;
			while (items_sent - phase_start < RANDOM_ITEMS / RANDOM_PHASES ||
				(p == RANDOM_PHASES - 1 && frames_sent - frame_start < RANDOM_FRAMES))
				send_random_frame();
			steady_phase = 1'b0;
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_valid        = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		in_valid         = 1'b0;
		req_type         = REQ_BYTE;
		pkt_byte         = '0;
		last_byte        = 1'b0;
		entry_index      = '0;
		entry_kind       = KIND_ETYPE;
		entry_value      = '0;
		steady_phase     = 1'b0;
		fail_count       = 0;
		items_sent       = 0;
		frames_sent      = 0;
		parse_offset     = '0;
		parse_outer      = '0;
		parse_inner      = '0;
		parse_proto      = '0;
		parse_proto_seen = 1'b0;
		pass_total       = '0;
		drop_total       = '0;
		pass_byte_total  = '0;
		cfg_match_act    = ACT_PASS;
		cfg_default_act  = ACT_PASS;
		cfg_entry_count  = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_table_fill();
		test_header_parse();
		test_entry_count();
		test_actions();
		test_table_write_midframe();
		test_long_frame();
		test_random_traffic();

		settle();
		if (pending_verdicts.size() != 0)
			report_mismatch("verdict beats never seen", 64'(pending_verdicts.size()), 64'd0);
		if (fail_count == 0) begin
			$display("ethertype_ipproto_packet_filter_core regression: pass");
		end else begin
			$display("ethertype_ipproto_packet_filter_core regression: fail");
		end
		$finish;
	end

endmodule
